>>> hw/rtl/pip_pkg.sv
package pip_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_WIDTH_DEF  = 32;

  // Width of the count fields in a result
  localparam int CNT_W = 9;

  // Edge test pipeline depth, test enable to hit
  localparam int PIPE_LAT = 4;

  // Request op codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } in_req_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
    logic [CNT_W-1:0] vertex_count;
    logic             status;
  } out_res_t;

endpackage

>>> hw/rtl/pip_cell.sv
// One vertex slot of the rotating vertex chain
module pip_cell #(
  parameter int CW  = pip_pkg::COORD_WIDTH_DEF,
  parameter int AW  = 8,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_idx,
  input  logic signed [CW-1:0] wr_x,
  input  logic signed [CW-1:0] wr_y,
  input  logic signed [CW-1:0] nb_x,
  input  logic signed [CW-1:0] nb_y,
  output logic signed [CW-1:0] x_r,
  output logic signed [CW-1:0] y_r
);

  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;

  // Rotate from the neighbor during a walk, load on an addressed append
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (shift_en) begin
      x_nxt = nb_x;
      y_nxt = nb_y;
    end else if (wr_en && (wr_idx == AW'(IDX))) begin
      x_nxt = wr_x;
      y_nxt = wr_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

endmodule

>>> hw/rtl/pip_edge_unit.sv
// Pipelined edge crossing test: straddle check, split cross multiply,
// product sum, signed compare
module pip_edge_unit #(
  parameter int CW = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 test_en,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] xq,
  input  logic signed [CW-1:0] yq,
  output logic                 hit
);

  localparam int DW  = CW + 1;    // difference width
  localparam int LO  = DW / 2;    // low split of the multiplier operand
  localparam int HI  = DW - LO;
  localparam int PW  = 2 * DW;    // full product width
  localparam int PLW = DW + LO + 1;
  localparam int PHW = DW + HI;

  // Stage 0: straddle and differences
  logic                 v0_r, dpos0_r;
  logic signed [DW-1:0] a1_r, b1_r, a2_r, b2_r;
  logic                 straddle;

  assign straddle = ((y0 <= yq) && (y1 > yq)) || ((y0 > yq) && (y1 <= yq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= test_en && straddle;
    end
  end

  always_ff @(posedge clk) begin
    dpos0_r <= (y1 > y0);
    a1_r    <= DW'(xq) - DW'(x0);
    b1_r    <= DW'(y1) - DW'(y0);
    a2_r    <= DW'(yq) - DW'(y0);
    b2_r    <= DW'(x1) - DW'(x0);
  end

  // Stage 1: partial products, operand b split in a low and a high part
  logic                  v1_r, dpos1_r;
  logic signed [PLW-1:0] pl1_r, pl2_r;
  logic signed [PHW-1:0] ph1_r, ph2_r;
  logic signed [LO:0]    b1_lo, b2_lo;
  logic signed [HI-1:0]  b1_hi, b2_hi;

  assign b1_lo = $signed({1'b0, b1_r[LO-1:0]});
  assign b2_lo = $signed({1'b0, b2_r[LO-1:0]});
  assign b1_hi = $signed(b1_r[DW-1:LO]);
  assign b2_hi = $signed(b2_r[DW-1:LO]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    dpos1_r <= dpos0_r;
    pl1_r   <= PLW'(a1_r) * PLW'(b1_lo);
    ph1_r   <= PHW'(a1_r) * PHW'(b1_hi);
    pl2_r   <= PLW'(a2_r) * PLW'(b2_lo);
    ph2_r   <= PHW'(a2_r) * PHW'(b2_hi);
  end

  // Stage 2: recombine into exact products
  logic                 v2_r, dpos2_r;
  logic signed [PW-1:0] lhs_r, rhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    dpos2_r <= dpos1_r;
    lhs_r   <= (PW'(ph1_r) <<< LO) + PW'(pl1_r);
    rhs_r   <= (PW'(ph2_r) <<< LO) + PW'(pl2_r);
  end

  // Stage 3: compare direction follows the sign of dy
  logic hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= v2_r && (dpos2_r ? (lhs_r < rhs_r) : (rhs_r < lhs_r));
    end
  end

  assign hit = hit_r;

endmodule

>>> hw/rtl/point_in_polygon_crossing_test_core.sv
// Point-in-polygon crossing test over a stored list of closed rings.
// Input channel: a request (op, x_coord, y_coord) is taken on the rising edge
// where start is high and busy is low. Op clear empties the vertex list, op
// append adds a vertex, op query tests a point against all stored edges.
// Result channel: every request gives one result, shown for one cycle with
// out_valid high; there is no backpressure, the receiver must take it.
// Clear, append and the unused op answer on the next cycle and do not raise
// busy, so such requests can follow each other on every cycle.
// A query rotates the vertex chain once around, one cell per cycle, so the
// walk covers all MAX_VERTICES cells whatever the vertex count, followed by
// a drain of the edge test pipeline: busy stays high through walk and drain
// and the result appears on the cycle after that.
// Reset (synchronous, rst_n low) empties the vertex list and drops any query
// in flight; stored vertex values are not cleared.
module point_in_polygon_crossing_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pip_pkg::in_req_t  in_req,
  output logic              out_valid,
  output pip_pkg::out_res_t out_res
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int LW = $clog2(pip_pkg::PIPE_LAT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [NW-1:0]        count_r, count_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [LW-1:0]        drain_r, drain_nxt;
  logic                 skip_r, skip_nxt;
  logic signed [CW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [CW-1:0] xq_r, xq_nxt, yq_r, yq_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pip_pkg::out_res_t    out_res_r, out_res_nxt;

  logic                 accept, shift_en, wr_en, test_en, hit;
  logic signed [CW-1:0] in_x, in_y, cur_sx, cur_sy;
  logic signed [CW-1:0] cell_x [MAX_VERTICES];
  logic signed [CW-1:0] cell_y [MAX_VERTICES];

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign in_x   = $signed(CW'(in_req.x_coord));
  assign in_y   = $signed(CW'(in_req.y_coord));

  // Vertex chain: cell 0 holds the current vertex, cell 1 the next one
  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pip_cell #(
      .CW  (CW),
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .wr_en    (wr_en),
      .wr_idx   (count_r[AW-1:0]),
      .wr_x     (in_x),
      .wr_y     (in_y),
      .nb_x     (cell_x[(i + 1) % MAX_VERTICES]),
      .nb_y     (cell_y[(i + 1) % MAX_VERTICES]),
      .x_r      (cell_x[i]),
      .y_r      (cell_y[i])
    );
  end

  pip_edge_unit #(
    .CW (CW)
  ) u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .test_en (test_en),
    .x0      (cell_x[0]),
    .y0      (cell_y[0]),
    .x1      (cell_x[1 % MAX_VERTICES]),
    .y1      (cell_y[1 % MAX_VERTICES]),
    .xq      (xq_r),
    .yq      (yq_r),
    .hit     (hit)
  );

  // Ring start seen by the walk: the first vertex until captured
  assign cur_sx = (k_r == '0) ? cell_x[0] : sx_r;
  assign cur_sy = (k_r == '0) ? cell_y[0] : sy_r;

  // Edge k is tested while k + 1 < count and it is not a ring closing skip
  assign test_en = (state_r == ST_WALK) && !skip_r && ((NW'(k_r) + NW'(1)) < count_r);
  assign shift_en = (state_r == ST_WALK);

  // Control sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    drain_nxt     = drain_r;
    skip_nxt      = skip_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    xq_nxt        = xq_r;
    yq_nxt        = yq_r;
    wr_en         = 1'b0;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;

    if (hit) begin
      cnt_nxt = cnt_r + NW'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_res_nxt.inside_res     = 1'b0;
          out_res_nxt.crossing_count = '0;
          out_res_nxt.status         = pip_pkg::ST_OK;
          case (in_req.op)
            pip_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            pip_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r < NW'(MAX_VERTICES)) begin
                wr_en     = 1'b1;
                count_nxt = count_r + NW'(1);
              end else begin
                out_res_nxt.status = pip_pkg::ST_FULL;
              end
            end
            pip_pkg::OP_QUERY: begin
              state_nxt = ST_WALK;
              k_nxt     = '0;
              cnt_nxt   = '0;
              skip_nxt  = 1'b0;
              xq_nxt    = in_x;
              yq_nxt    = in_y;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_res_nxt.vertex_count = pip_pkg::CNT_W'(count_nxt);
        end
      end

      ST_WALK: begin
        if (k_r == '0) begin
          sx_nxt = cell_x[0];
          sy_nxt = cell_y[0];
        end
        if (test_en) begin
          // Next vertex closes the ring: skip it, the one after starts anew
          skip_nxt = (cell_x[1 % MAX_VERTICES] == cur_sx) &&
                     (cell_y[1 % MAX_VERTICES] == cur_sy);
        end else if (skip_r) begin
          skip_nxt = 1'b0;
          sx_nxt   = cell_x[1 % MAX_VERTICES];
          sy_nxt   = cell_y[1 % MAX_VERTICES];
        end
        k_nxt = k_r + AW'(1);
        if (k_r == AW'(MAX_VERTICES - 1)) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end
      end

      ST_DRAIN: begin
        drain_nxt = drain_r + LW'(1);
        if (drain_r == LW'(pip_pkg::PIPE_LAT - 1)) begin
          state_nxt                  = ST_IDLE;
          out_valid_nxt              = 1'b1;
          out_res_nxt.inside_res     = cnt_nxt[0];
          out_res_nxt.crossing_count = pip_pkg::CNT_W'(cnt_nxt);
          out_res_nxt.vertex_count   = pip_pkg::CNT_W'(count_r);
          out_res_nxt.status         = pip_pkg::ST_OK;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      skip_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      skip_r      <= skip_nxt;
    end
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    k_r       <= k_nxt;
    drain_r   <= drain_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    xq_r      <= xq_nxt;
    yq_r      <= yq_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Checks
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_count_held : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |=> $stable(count_r))
    else $error("vertex count changed during a query walk");

  a_hit_in_query : assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (state_r != ST_IDLE))
    else $error("edge hit outside a query");

  a_query_no_early : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.op == pip_pkg::OP_QUERY)) |=> (busy && !out_valid))
    else $error("query answered without a walk");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pip_pkg::*;

  localparam int MAX_V      = MAX_VERTICES_DEF;
  localparam int N_ITEMS    = 1750;
  localparam int IDLE_LIMIT = 2000;

  // op code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // coordinate spreads for generated points
  localparam int unsigned SPAN_RAW  = 0;
  localparam int unsigned SPAN_UNIT = 1;
  localparam int unsigned SPAN_FULL = 2;

  localparam int C_MIN = int'(32'h8000_0000);
  localparam int C_MAX = int'(32'h7FFF_FFFF);

  // Vertex list mirror and expected answers, one per request
  class pip_scoreboard;
    longint      vx[MAX_V];
    longint      vy[MAX_V];
    int unsigned n_stored;
    out_res_t    expected_q[$];
    int unsigned mismatches;

    function new();
      n_stored   = 0;
      mismatches = 0;
    endfunction

    // exact ray test of edge i -> j against the point, no division
    function bit edge_hits(int i, int j, longint xq, longint yq);
      logic signed [67:0] dx_q, dy_q, dx_e, dy_e;
      bit straddle;
      straddle = (vy[i] <= yq && vy[j] > yq) || (vy[i] > yq && vy[j] <= yq);
      if (!straddle) return 1'b0;
      dx_q = 68'(xq) - 68'(vx[i]);
      dy_q = 68'(yq) - 68'(vy[i]);
      dx_e = 68'(vx[j]) - 68'(vx[i]);
      dy_e = 68'(vy[j]) - 68'(vy[i]);
      if (dy_e > 0) return (dx_q * dy_e) < (dy_q * dx_e);
      return (dy_q * dx_e) < (dx_q * dy_e);
    endfunction

    // walk all stored edges; a vertex equal to the ring start closes the ring
    function int unsigned count_crossings(longint xq, longint yq);
      int unsigned idx, ring_start, hits;
      idx        = 0;
      ring_start = 0;
      hits       = 0;
      if (n_stored < 2) return 0;
      while (idx < n_stored - 1) begin
        if (edge_hits(idx, idx + 1, xq, yq)) hits++;
        idx++;
        if (vx[idx] == vx[ring_start] && vy[idx] == vy[ring_start]) begin
          idx++;
          ring_start = idx;
        end
      end
      return hits;
    endfunction

    function void note_request(in_req_t r);
      out_res_t    e;
      int unsigned hits;
      e = '0;
      case (r.op)
        OP_CLEAR: n_stored = 0;
        OP_APPEND: begin
          if (n_stored < MAX_V) begin
            vx[n_stored] = longint'($signed(r.x_coord));
            vy[n_stored] = longint'($signed(r.y_coord));
            n_stored++;
          end else begin
            e.status = ST_FULL;
          end
        end
        OP_QUERY: begin
          hits = count_crossings(longint'($signed(r.x_coord)),
                                 longint'($signed(r.y_coord)));
          e.crossing_count = CNT_W'(hits);
          e.inside_res     = hits[0];
        end
        default: ;
      endcase
      e.vertex_count = CNT_W'(n_stored);
      expected_q.push_back(e);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with no request pending: in=%0d cross=%0d vcnt=%0d st=%0d",
                       got.inside_res, got.crossing_count, got.vertex_count, got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.inside_res !== want.inside_res || got.crossing_count !== want.crossing_count ||
          got.vertex_count !== want.vertex_count || got.status !== want.status)
        flag($sformatf({"result mismatch: want in=%0d cross=%0d vcnt=%0d st=%0d,",
                        " got in=%0d cross=%0d vcnt=%0d st=%0d"},
                       want.inside_res, want.crossing_count, want.vertex_count, want.status,
                       got.inside_res, got.crossing_count, got.vertex_count, got.status));
    endfunction
  endclass

  logic     clk;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_res_t out_res;

  pip_scoreboard sb = new();

  int unsigned sent        = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle     = 1'b0;
  int          hist_x[$];
  int          hist_y[$];

  wire req_taken = rst_n && start && !busy;

  point_in_polygon_crossing_test_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: results first, then the request taken on this edge
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
    if (req_taken) sb.note_request(in_req);
  end

  // Watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (req_taken || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic int pick_coord(int unsigned span);
    int v;
    case (span)
      SPAN_RAW: v = int'($urandom_range(16)) - 8;
      SPAN_UNIT: begin
        v = (int'($urandom_range(32)) - 16) * 65536;
        if ($urandom_range(3) == 0) v += int'($urandom_range(65535));
      end
      default: begin
        case ($urandom_range(9))
          0:       v = C_MIN;
          1:       v = C_MAX;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] op, input int x, input int y);
    in_req_t     r;
    int unsigned gap;
    r.op      = op;
    r.x_coord = x;
    r.y_coord = y;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    // track stored vertices so queries can aim at them
    if (op == OP_CLEAR) begin
      hist_x.delete();
      hist_y.delete();
    end else if (op == OP_APPEND && hist_x.size() < MAX_V) begin
      hist_x.push_back(x);
      hist_y.push_back(y);
    end
  endtask

  // query, often on a stored vertex's y (and sometimes its x too)
  task automatic run_query(input int unsigned span);
    int qx, qy, k;
    qx = pick_coord(span);
    qy = pick_coord(span);
    if (hist_x.size() != 0 && $urandom_range(9) < 4) begin
      k  = $urandom_range(hist_x.size() - 1);
      qy = hist_y[k];
      if ($urandom_range(1) == 1) qx = hist_x[k];
    end
    send_request(OP_QUERY, qx, qy);
  endtask

  // ring of random corners, usually closed by repeating its first vertex
  task automatic build_ring(input int unsigned span, input int unsigned corners);
    int fx, fy;
    fx = pick_coord(span);
    fy = pick_coord(span);
    send_request(OP_APPEND, fx, fy);
    repeat (corners - 1) send_request(OP_APPEND, pick_coord(span), pick_coord(span));
    if ($urandom_range(9) != 0) send_request(OP_APPEND, fx, fy);
  endtask

  initial begin
    int unsigned span, kind;
    bit          filled_once;
    filled_once = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, unused op, single vertex
    send_request(OP_QUERY, 0, 0);
    send_request(OP_UNUSED, C_MAX, C_MIN);
    send_request(OP_APPEND, C_MIN, C_MIN);
    send_request(OP_QUERY, C_MAX, C_MAX);
    // square spanning the whole coordinate range, closed on its start
    send_request(OP_APPEND, C_MAX, C_MIN);
    send_request(OP_APPEND, C_MAX, C_MAX);
    send_request(OP_APPEND, C_MIN, C_MAX);
    send_request(OP_APPEND, C_MIN, C_MIN);
    send_request(OP_QUERY, 0, 0);
    send_request(OP_QUERY, C_MIN, 0);
    send_request(OP_QUERY, C_MAX, 0);
    send_request(OP_QUERY, 0, C_MIN);
    send_request(OP_QUERY, C_MIN, C_MIN);
    // small hole around the origin
    send_request(OP_APPEND, -1, -1);
    send_request(OP_APPEND, 1, -1);
    send_request(OP_APPEND, 1, 1);
    send_request(OP_APPEND, -1, 1);
    send_request(OP_APPEND, -1, -1);
    send_request(OP_QUERY, 0, 0);
    send_request(OP_QUERY, 1, 0);
    send_request(OP_UNUSED, 0, 0);
    send_request(OP_CLEAR, C_MAX, C_MAX);
    send_request(OP_QUERY, 0, 0);

    // random scenes
    while (sent < N_ITEMS) begin
      kind    = $urandom_range(99);
      span    = $urandom_range(SPAN_FULL);
      no_idle = ($urandom_range(3) == 0);
      if (!filled_once || kind < 5) begin
        // fill the store, push past full, then query the big list
        filled_once = 1'b1;
        send_request(OP_CLEAR, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL));
        while (hist_x.size() < MAX_V) build_ring(span, $urandom_range(12, 3));
        repeat ($urandom_range(3, 1))
          send_request(OP_APPEND, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL));
        repeat ($urandom_range(5, 2)) run_query(span);
      end else if (kind < 85) begin
        // polygon of one to three rings of random corners, then queries
        if ($urandom_range(7) != 0)
          send_request(OP_CLEAR, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL));
        repeat ($urandom_range(3, 1)) build_ring(span, $urandom_range(8, 3));
        repeat ($urandom_range(8, 2)) run_query(span);
      end else begin
        // noise: any op with any coordinates
        repeat ($urandom_range(6, 1))
          send_request(2'($urandom_range(3)), pick_coord(SPAN_FULL),
                       pick_coord(SPAN_FULL));
      end
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (MAX_V + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
